### rtl/core/ngd_pkg.sv
// Shared types and constants for the next greater distance unit.
package ngd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int POS_W    = 5;
   localparam int DIST_W   = 5;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_value;
      logic                end_of_sequence;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [DIST_W-1:0] distance;
      logic              last_of_run;
      logic              sequence_finished;
      logic              overflow;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic pop;
      logic push;
      logic flush_pop;
   } ngd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic top_less;
      logic depth_one;
      logic seq_full;
      logic req_last;
      logic item_last;
      logic out_free;
   } ngd_status_type;

endpackage

### rtl/core/ngd_ctrl.sv
// Sequencing state machine for the next greater distance unit.
module ngd_ctrl
   import ngd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ngd_status_type status,
   output ngd_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_POP   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               // A value past the length limit is dropped; only its end flag matters.
               if (!status.seq_full) begin
                  state_in = ST_POP;
               end else if (status.req_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_POP: begin
            if (status.top_less) begin
               if (status.out_free) begin
                  cmd.pop = 1'b1;
               end
            end else begin
               cmd.push = 1'b1;
               state_in = status.item_last ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush_pop = 1'b1;
               if (status.depth_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/ngd_dpath.sv
// Stack memory, top-of-stack cache, compare logic and result register.
module ngd_dpath
   import ngd_pkg::*;
#(
   parameter int MAX_LEN    = 32,
   parameter int VALUE_BITS = 16
)
(
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   output rsp_type        rsp_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  ngd_cmd_type    cmd,
   output ngd_status_type status
);

   localparam int CMP_W = (VALUE_BITS < SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
   localparam int D_W   = $clog2(MAX_LEN + 1);
   localparam int A_W   = $clog2(MAX_LEN);

   logic [CMP_W-1:0] mem_val [MAX_LEN];
   logic [POS_W-1:0] mem_pos [MAX_LEN];

   logic [CMP_W-1:0] value_ff;
   logic             last_ff;
   logic [POS_W-1:0] cur_ff;
   logic [CMP_W-1:0] top_val_ff;
   logic [POS_W-1:0] top_pos_ff;
   logic [CMP_W-1:0] rd_val_ff;
   logic [POS_W-1:0] rd_pos_ff;
   logic [D_W-1:0]   depth_ff, depth_in;
   logic [D_W-1:0]   next_pos_ff;
   logic             ovf_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic [D_W+POS_W-1:0] next_pos_ext;
   logic [D_W-1:0]       raddr_full, waddr_full;
   logic [A_W-1:0]       raddr, waddr;
   logic                 mem_we;
   logic                 next_less;

   assign next_pos_ext = {{POS_W{1'b0}}, next_pos_ff};
   assign next_less    = (rd_val_ff < value_ff);

   assign status.top_less  = (depth_ff != '0) && (top_val_ff < value_ff);
   assign status.depth_one = (depth_ff == D_W'(1));
   assign status.seq_full  = (next_pos_ff >= D_W'(MAX_LEN));
   assign status.req_last  = req_data.end_of_sequence;
   assign status.item_last = last_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      depth_in = depth_ff;
      if (cmd.push) begin
         depth_in = depth_ff + D_W'(1);
      end else if (cmd.pop || cmd.flush_pop) begin
         depth_in = depth_ff - D_W'(1);
      end
   end

   // The read address follows the next depth: the entry under the new top is
   // ready next cycle, and pops run one per cycle while the output is free.
   assign raddr_full = depth_in - D_W'(2);
   assign raddr      = raddr_full[A_W-1:0];
   assign waddr_full = depth_ff - D_W'(1);
   assign waddr      = waddr_full[A_W-1:0];
   assign mem_we     = cmd.push && (depth_ff != '0);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_val[waddr] <= top_val_ff;
         mem_pos[waddr] <= top_pos_ff;
      end
      if (mem_we && (waddr == raddr)) begin
         rd_val_ff <= top_val_ff;
         rd_pos_ff <= top_pos_ff;
      end else begin
         rd_val_ff <= mem_val[raddr];
         rd_pos_ff <= mem_pos[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         value_ff <= req_data.sample_value[CMP_W-1:0];
         last_ff  <= req_data.end_of_sequence;
         cur_ff   <= next_pos_ext[POS_W-1:0];
      end
      if (cmd.push) begin
         top_val_ff <= value_ff;
         top_pos_ff <= cur_ff;
      end else if (cmd.pop || cmd.flush_pop) begin
         top_val_ff <= rd_val_ff;
         top_pos_ff <= rd_pos_ff;
      end
      if (cmd.pop) begin
         rsp_ff.position          <= top_pos_ff;
         rsp_ff.distance          <= cur_ff - top_pos_ff;
         rsp_ff.last_of_run       <= !last_ff && (status.depth_one || !next_less);
         rsp_ff.sequence_finished <= 1'b0;
         rsp_ff.overflow          <= ovf_ff;
      end else if (cmd.flush_pop) begin
         rsp_ff.position          <= top_pos_ff;
         rsp_ff.distance          <= '0;
         rsp_ff.last_of_run       <= status.depth_one;
         rsp_ff.sequence_finished <= status.depth_one;
         rsp_ff.overflow          <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         next_pos_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         if (cmd.accept && status.seq_full) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.push) begin
            next_pos_ff <= next_pos_ff + D_W'(1);
         end
         if (cmd.flush_pop && status.depth_one) begin
            next_pos_ff <= '0;
            ovf_ff      <= 1'b0;
         end
         if (cmd.pop || cmd.flush_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= D_W'(MAX_LEN))
      else $error("stack depth exceeds its limit");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.flush_pop) |-> status.out_free)
      else $error("result produced while the output register is occupied");

   assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> status.top_less)
      else $error("pop without a smaller stacked value");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.flush_pop && status.depth_one) |=> (depth_ff == '0) && (next_pos_ff == '0))
      else $error("sequence state not cleared after flush");

endmodule

### rtl/core/next_greater_distance_unit.sv
// Next greater distance unit: a monotonic stack reporting, for each value of a sequence,
// the position and the distance to the next strictly greater value. An item is first
// transferred, then pops each result it releases (one stack memory read each) and is
// pushed; a sequence's final item then flushes the stacked entries one at a time. A value
// dropped after MAX_LEN values is only transferred, or flushes the stack if it is final.
// No new item is taken until the last is through. Results leave through a single output register.
module next_greater_distance_unit
   import ngd_pkg::*;
#(
   parameter int MAX_LEN    = 32,
   parameter int VALUE_BITS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ngd_cmd_type    cmd;
   ngd_status_type status;

   ngd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ngd_dpath #(
      .MAX_LEN    (MAX_LEN),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### test/next_greater_distance_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the next greater distance unit: stack predictor and result compare.
module next_greater_distance_unit_checker
   import ngd_pkg::*;
#(
   parameter int MAX_LEN = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      answers_due
);

   logic [SAMPLE_W-1:0] open_values    [MAX_LEN];
   logic [POS_W-1:0]    open_positions [MAX_LEN];
   int                  open_depth;
   int                  next_pos;
   bit                  dropped;
   rsp_type             pending_answers [$];

   // Works out every answer that one accepted sample releases.
   task automatic answer_sample(input req_type item);
      rsp_type batch [$];
      rsp_type r;
      int      cur;
      if (next_pos < MAX_LEN) begin
         cur = next_pos;
         while (open_depth > 0 && open_values[open_depth-1] < item.sample_value) begin
            open_depth--;
            r                   = '0;
            r.position          = open_positions[open_depth];
            r.distance          = DIST_W'(cur - int'(open_positions[open_depth]));
            r.overflow          = dropped;
            batch               = {batch, r};
         end
         open_values[open_depth]    = item.sample_value;
         open_positions[open_depth] = POS_W'(cur);
         open_depth++;
         next_pos = cur + 1;
      end else begin
         dropped = 1'b1;
      end
      if (item.end_of_sequence) begin
         // The flush reports the remaining entries top first with no answer.
         while (open_depth > 0) begin
            open_depth--;
            r                   = '0;
            r.position          = open_positions[open_depth];
            r.sequence_finished = (open_depth == 0);
            r.overflow          = dropped;
            batch               = {batch, r};
         end
         next_pos = 0;
      end
      if (batch.size() > 0) begin
         r             = batch[batch.size()-1];
         r.last_of_run = 1'b1;
         batch[batch.size()-1] = r;
      end
      if (item.end_of_sequence) begin
         dropped = 1'b0;
      end
      pending_answers = {pending_answers, batch};
   endtask

   task automatic compare_answer(input rsp_type got);
      rsp_type want;
      if (pending_answers.size() == 0) begin
         $error("unexpected result: position %0d distance %0d", got.position, got.distance);
         mismatch_count++;
      end else begin
         want = pending_answers.pop_front();
         if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            mismatch_count++;
         end
         if (got.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
            mismatch_count++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            mismatch_count++;
         end
         if (got.sequence_finished !== want.sequence_finished) begin
            $error("sequence_finished: expected %0b, got %0b",
                   want.sequence_finished, got.sequence_finished);
            mismatch_count++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         open_depth = 0;
         next_pos   = 0;
         dropped    = 1'b0;
         pending_answers.delete();
      end else begin
         // A result leaving at this edge always belongs to an earlier sample.
         if (rsp_valid && !rsp_stall) begin
            compare_answer(rsp_data);
         end
         if (req_valid && !req_stall) begin
            answer_sample(req_data);
         end
      end
      answers_due = pending_answers.size();
   end

endmodule

### test/next_greater_distance_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the next greater distance unit: stimulus, idling phases and verdict.
module next_greater_distance_unit_test;
   import ngd_pkg::*;

   localparam int TOTAL_SAMPLES = 310;
   localparam int QUIET_LIMIT   = 2000;

   typedef enum int {
      PHASE_STEADY,
      PHASE_SENDER_IDLE,
      PHASE_RECEIVER_STALL,
      PHASE_BOTH
   } phase_type;

   typedef enum int {
      SHAPE_WIDE,
      SHAPE_NARROW,
      SHAPE_FALLING
   } shape_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int answers_due;
   int samples_sent = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   next_greater_distance_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   next_greater_distance_unit_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .answers_due    (answers_due)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("next_greater_distance_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void set_phase(input phase_type phase);
      idle_pct  = (phase == PHASE_SENDER_IDLE) ? 68 : (phase == PHASE_BOTH) ? 17 : 0;
      stall_pct = (phase == PHASE_RECEIVER_STALL) ? 68 : (phase == PHASE_BOTH) ? 17 : 0;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample_value: value, end_of_sequence: last};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      samples_sent++;
   endtask

   task automatic send_sequence(input int length, input shape_type shape);
      logic [SAMPLE_W-1:0] value;
      for (int i = 0; i < length; i++) begin
         case (shape)
            SHAPE_NARROW: begin
               value = SAMPLE_W'($urandom_range(3));
            end
            SHAPE_FALLING: begin
               // A falling run piles up the stack; the final peak empties it in one go.
               value = (i == length - 1) ? '1 :
                       SAMPLE_W'(60000 - i * 1000 - $urandom_range(999));
            end
            default: begin
               if ($urandom_range(7) == 0) begin
                  value = $urandom_range(1) ? '1 : '0;
               end else begin
                  value = SAMPLE_W'($urandom);
               end
            end
         endcase
         send_sample(value, i == length - 1);
      end
   endtask

   initial begin
      int directed_count;
      int step;
      int pick;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_phase(PHASE_STEADY);

      // Single value: the flush reports it alone.
      send_sample(16'hFFFF, 1'b1);
      // Equal values are not strictly greater, so nothing pops until the flush.
      send_sample(16'd5, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'd5, 1'b1);
      // A peak at the end pops the whole falling run.
      send_sample(16'd40000, 1'b0);
      send_sample(16'd300, 1'b0);
      send_sample(16'd200, 1'b0);
      send_sample(16'd100, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      // Rising values each answer the one before.
      send_sample(16'd1, 1'b0);
      send_sample(16'd2, 1'b0);
      send_sample(16'd3, 1'b0);
      send_sample(16'd4, 1'b1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b1);
      directed_count = samples_sent;

      while (samples_sent < TOTAL_SAMPLES) begin
         step = ((samples_sent - directed_count) * 4) / (TOTAL_SAMPLES - directed_count);
         set_phase(phase_type'((step > 3) ? 3 : step));
         pick = $urandom_range(9);
         if (pick < 4) begin
            send_sequence($urandom_range(1, 12), SHAPE_WIDE);
         end else if (pick < 6) begin
            send_sequence($urandom_range(1, 10), SHAPE_NARROW);
         end else if (pick < 8) begin
            send_sequence($urandom_range(1) ? 32 : $urandom_range(8, 31), SHAPE_FALLING);
         end else begin
            // Too long: the tail is dropped and the overflow flag shows up in the flush.
            send_sequence($urandom_range(33, 40),
                          $urandom_range(1) ? SHAPE_WIDE : SHAPE_NARROW);
         end
      end
      req_valid <= 1'b0;

      while (answers_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("next_greater_distance_unit: match");
      end else begin
         $display("next_greater_distance_unit: mismatch");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/ngd_pkg.sv
rtl/core/ngd_ctrl.sv
rtl/core/ngd_dpath.sv
rtl/core/next_greater_distance_unit.sv
test/next_greater_distance_unit_checker.sv
test/next_greater_distance_unit_test.sv
